>>> design/lcfr_pkg.sv
package lcfr_pkg;

   // default sizes
   localparam int MAX_PAYLOAD_DEF = 40;
   localparam int NUM_PAGES_DEF   = 5;

   // register reset values
   localparam logic [7:0] HEADER_RESET = 8'hEE;
   localparam logic [7:0] TAIL_RESET   = 8'hEF;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL   = 2'd1;

   // result kinds
   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_EMPTY     = 3'd1,
      KIND_TOO_LONG  = 3'd2,
      KIND_BAD_COMPL = 3'd3,
      KIND_BAD_TAIL  = 3'd4
   } kind_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic eval;
      logic emit_step;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
      logic start_emit;
      logic emit_last;
   } status_type;

endpackage

>>> design/lcfr_if.sv
interface lcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [2:0] page;
   logic [5:0] offset;
   logic [7:0] data_byte;
   logic [7:0] frame_length;
   logic       last;

   modport source (output valid, output kind, output page, output offset,
                   output data_byte, output frame_length, output last, input ready);
   modport sink (input valid, input kind, input page, input offset,
                 input data_byte, input frame_length, input last, output ready);
endinterface

>>> design/lcfr_ctrl.sv
module lcfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lcfr_pkg::status_type status,
   output lcfr_pkg::cmd_type    cmd
);
   import lcfr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.capture   = req_valid && ready_ff;
      cmd.eval      = 1'b0;
      cmd.emit_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.out_free) begin
               cmd.eval = 1'b1;
               state_in = status.start_emit ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_step = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

>>> design/lcfr_dp.sv
module lcfr_dp #(
   parameter int MAX_PAYLOAD = lcfr_pkg::MAX_PAYLOAD_DEF,
   parameter int NUM_PAGES   = lcfr_pkg::NUM_PAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                csr_write_en,
   input  logic [lcfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_wdata,
   input  lcfr_pkg::cmd_type                   cmd,
   output lcfr_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_kind,
   output logic [2:0]                          rsp_page,
   output logic [5:0]                          rsp_offset,
   output logic [7:0]                          rsp_data_byte,
   output logic [7:0]                          rsp_frame_length,
   output logic                                rsp_last
);
   import lcfr_pkg::*;

   localparam int PW  = $clog2(MAX_PAYLOAD + 2);
   localparam int AW  = $clog2(MAX_PAYLOAD);
   localparam int PGW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   // configuration registers
   logic [7:0] header_ff;
   logic [7:0] tail_ff;

   // frame state
   logic           in_frame_ff, in_frame_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [7:0]     frame_len_ff, frame_len_in;
   logic           length_ok_ff, length_ok_in;
   logic [PGW-1:0] page_ff, page_in;

   // held input byte
   logic [7:0] byte_ff;

   // payload buffer and read side
   logic [7:0]    pay_mem [MAX_PAYLOAD];
   logic [7:0]    rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   // emission state
   logic [AW-1:0]  emit_idx_ff;
   logic [7:0]     emit_len_ff;
   logic [PGW-1:0] emit_page_ff;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_kind_ff;
   logic [2:0] out_page_ff;
   logic [5:0] out_offset_ff;
   logic [7:0] out_data_ff;
   logic [7:0] out_len_ff;
   logic       out_last_ff;

   // evaluation of the held byte
   logic           ev_result;
   kind_type       ev_kind;
   logic [2:0]     ev_page;
   logic [7:0]     ev_len;
   logic           ev_start_emit;
   logic           ev_cleared;
   logic [PGW-1:0] page_next;

   assign page_next = (page_ff == PGW'(NUM_PAGES - 1)) ? '0 : page_ff + PGW'(1);

   always_comb begin
      in_frame_in   = in_frame_ff;
      pos_in        = pos_ff;
      frame_len_in  = frame_len_ff;
      length_ok_in  = length_ok_ff;
      page_in       = page_ff;
      ev_result     = 1'b0;
      ev_kind       = KIND_PAYLOAD;
      ev_page       = 3'd0;
      ev_len        = 8'd0;
      ev_start_emit = 1'b0;
      ev_cleared    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = AW'(pos_ff - PW'(1));
      if (in_frame_ff) begin
         priority if (pos_ff == '0) begin
            frame_len_in = byte_ff;
            if ({1'b0, byte_ff} >= 9'(MAX_PAYLOAD)) begin
               ev_result  = 1'b1;
               ev_kind    = KIND_TOO_LONG;
               ev_len     = byte_ff;
               ev_cleared = 1'b1;
            end else begin
               pos_in = PW'(1);
            end
         end else if (10'(pos_ff) == 10'(frame_len_ff) + 10'd1) begin
            if (byte_ff == ~frame_len_ff) begin
               length_ok_in = 1'b1;
               pos_in       = pos_ff + PW'(1);
            end else begin
               ev_result  = 1'b1;
               ev_kind    = KIND_BAD_COMPL;
               ev_len     = frame_len_ff;
               ev_cleared = 1'b1;
            end
         end else if (10'(pos_ff) == 10'(frame_len_ff) + 10'd2) begin
            ev_cleared = 1'b1;
            if (byte_ff == tail_ff && length_ok_ff) begin
               page_in = page_next;
               if (frame_len_ff == 8'd0) begin
                  ev_result = 1'b1;
                  ev_kind   = KIND_EMPTY;
                  ev_page   = 3'(page_ff);
               end else begin
                  ev_start_emit = 1'b1;
               end
            end else begin
               ev_result = 1'b1;
               ev_kind   = KIND_BAD_TAIL;
               ev_len    = frame_len_ff;
            end
         end else begin
            wr_en  = 1'b1;
            pos_in = pos_ff + PW'(1);
         end
      end
      if (ev_cleared) begin
         in_frame_in  = 1'b0;
         pos_in       = '0;
         frame_len_in = 8'd0;
         length_ok_in = 1'b0;
      end
      // a byte that ends a frame or arrives idle may open the next one
      if (!in_frame_in && byte_ff == header_ff) begin
         in_frame_in = 1'b1;
         pos_in      = '0;
      end
   end

   // status to the controller
   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.start_emit = ev_start_emit;
   assign status.emit_last  = (8'(emit_idx_ff) == emit_len_ff - 8'd1);

   // buffer read requests
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.eval && ev_start_emit) begin
         rd_en = 1'b1;
      end else if (cmd.emit_step && !status.emit_last) begin
         rd_en   = 1'b1;
         rd_addr = emit_idx_ff + AW'(1);
      end
   end

   // output valid next value
   always_comb begin
      out_valid_in = out_valid_ff;
      if ((cmd.eval && ev_result) || cmd.emit_step) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= HEADER_RESET;
         tail_ff      <= TAIL_RESET;
         in_frame_ff  <= 1'b0;
         pos_ff       <= '0;
         frame_len_ff <= 8'd0;
         length_ok_ff <= 1'b0;
         page_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en && csr_index == CSR_HEADER) begin
            header_ff <= csr_wdata;
         end
         if (csr_write_en && csr_index == CSR_TAIL) begin
            tail_ff <= csr_wdata;
         end
         if (cmd.eval) begin
            in_frame_ff  <= in_frame_in;
            pos_ff       <= pos_in;
            frame_len_ff <= frame_len_in;
            length_ok_ff <= length_ok_in;
            page_ff      <= page_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // payload buffer
   always_ff @(posedge clock) begin
      if (cmd.eval && wr_en) begin
         pay_mem[wr_addr] <= byte_ff;
      end
      if (rd_en) begin
         rd_data_ff <= pay_mem[rd_addr];
      end
   end

   // held byte, emission counters and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= req_rx_byte;
      end
      if (cmd.eval && ev_start_emit) begin
         emit_idx_ff  <= '0;
         emit_len_ff  <= frame_len_ff;
         emit_page_ff <= page_ff;
      end else if (cmd.emit_step && !status.emit_last) begin
         emit_idx_ff <= emit_idx_ff + AW'(1);
      end
      if (cmd.eval && ev_result) begin
         out_kind_ff   <= ev_kind;
         out_page_ff   <= ev_page;
         out_offset_ff <= 6'd0;
         out_data_ff   <= 8'd0;
         out_len_ff    <= ev_len;
         out_last_ff   <= 1'b1;
      end else if (cmd.emit_step) begin
         out_kind_ff   <= KIND_PAYLOAD;
         out_page_ff   <= 3'(emit_page_ff);
         out_offset_ff <= 6'(emit_idx_ff);
         out_data_ff   <= rd_data_ff;
         out_len_ff    <= emit_len_ff;
         out_last_ff   <= status.emit_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_page         = out_page_ff;
   assign rsp_offset       = out_offset_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_last         = out_last_ff;

endmodule

>>> design/length_checked_frame_receiver_top.sv
// channel   dir  handshake             payload
// req_bus   in   valid/ready transfer  rx_byte
// rsp_bus   out  valid/ready transfer  kind, page, offset, data_byte, frame_length, last
// csr_*     in   write enable only     csr_index, csr_wdata
//
// a byte is taken in one cycle and evaluated in the next once the output register is free
// a byte that causes no result or one result passes through the idle and evaluation states
// a frame accepted with L payload bytes emits one result per cycle while rsp is not stalled,
// from the buffer's single read port, so its tail byte also holds the input through L emission steps
// synchronous reset restores the register defaults and clears frame and page state
// the buffer needs no clearing pass; every entry is written before it is read
module length_checked_frame_receiver_top #(
   parameter int MAX_PAYLOAD = lcfr_pkg::MAX_PAYLOAD_DEF,
   parameter int NUM_PAGES   = lcfr_pkg::NUM_PAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   lcfr_req_if.sink                         req_bus,
   lcfr_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_en,
   input  logic [lcfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);
   import lcfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing of evaluation and payload emission
   lcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame state, payload buffer and output register
   lcfr_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .NUM_PAGES   (NUM_PAGES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_bus.rx_byte),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_kind         (rsp_bus.kind),
      .rsp_page         (rsp_bus.page),
      .rsp_offset       (rsp_bus.offset),
      .rsp_data_byte    (rsp_bus.data_byte),
      .rsp_frame_length (rsp_bus.frame_length),
      .rsp_last         (rsp_bus.last)
   );

`ifndef NO_ASSERTIONS
   // a payload result lies inside its frame
   a_offset_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_PAYLOAD) |->
         ({2'b00, rsp_bus.offset} < rsp_bus.frame_length))
      else $error("payload offset beyond frame length");

   // marker and error results are always the only result of their byte
   a_single_result_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind != KIND_PAYLOAD) |-> rsp_bus.last)
      else $error("non-payload result without last");

   // a taken byte is evaluated before the next one is taken
   a_one_byte_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("input taken while a byte is pending");
`endif

endmodule

>>> test/tb_top.sv
module tb_top;
   import lcfr_pkg::*;

   localparam int MAX_LEN      = MAX_PAYLOAD_DEF;
   localparam int PAGE_COUNT   = NUM_PAGES_DEF;
   localparam int SETTLE_TICKS = 8;
   localparam int TAIL_TICKS   = 20;

   // indexes past the two real registers, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] page;
      logic [5:0] offset;
      logic [7:0] data_byte;
      logic [7:0] frame_length;
      logic       last;
   } rx_result_t;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {
      BY_MODEL,
      TYPED_NONE,
      TYPED_ONE
   } row_check_t;

   typedef struct packed {
      logic [7:0] rx_byte;
      row_check_t how;
      kind_type   kind;
      logic [7:0] frame_length;
   } dir_row_t;

   localparam int DIR_ROWS = 25;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0] csr_wdata;

   lcfr_req_if req ();
   lcfr_rsp_if rsp ();

   length_checked_frame_receiver_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req),
      .rsp_bus      (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // frame tracker state and register shadows
   logic [7:0] hdr_reg;
   logic [7:0] tail_reg;
   bit         fr_open;
   int         fr_pos;
   logic [7:0] fr_len;
   bit         len_ok;
   logic [2:0] page_ctr;
   logic [7:0] frame_buf [MAX_LEN];

   rx_result_t predicted[$];
   rx_result_t awaited_results[$];
   rx_result_t want_r;
   int mismatches;
   int bytes_taken;
   int send_idle_pct;
   int recv_stall_pct;

   // directed stimulus: reset settings, header 0xEE, tail 0xEF
   dir_row_t dir_table [DIR_ROWS] = '{
      '{8'h00, TYPED_NONE, KIND_PAYLOAD,   8'h00},  // idle byte, ignored
      '{8'hEE, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'h28, TYPED_ONE,  KIND_TOO_LONG,  8'h28},  // length at buffer size
      '{8'hEE, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'hFF, TYPED_ONE,  KIND_TOO_LONG,  8'hFF},  // largest length
      '{8'hEE, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'h00, TYPED_NONE, KIND_PAYLOAD,   8'h00},  // empty frame
      '{8'hFF, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'hEF, TYPED_ONE,  KIND_EMPTY,     8'h00},
      '{8'hEE, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'h02, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'hEE, TYPED_NONE, KIND_PAYLOAD,   8'h00},  // header value as payload
      '{8'h00, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'h00, TYPED_ONE,  KIND_BAD_COMPL, 8'h02},
      '{8'hEE, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'h01, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'hFF, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'hFE, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'hEE, TYPED_ONE,  KIND_BAD_TAIL,  8'h01},  // bad tail reopens a frame
      '{8'h01, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'h55, BY_MODEL,   KIND_PAYLOAD,   8'h00},
      '{8'hFE, BY_MODEL,   KIND_PAYLOAD,   8'h00},
      '{8'hEF, BY_MODEL,   KIND_PAYLOAD,   8'h00},  // accepted, second page
      '{8'hEE, TYPED_NONE, KIND_PAYLOAD,   8'h00},
      '{8'hEE, TYPED_ONE,  KIND_TOO_LONG,  8'hEE}   // too long, and reopens
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void drop_frame();
      fr_open = 1'b0;
      fr_pos  = 0;
      fr_len  = 8'd0;
      len_ok  = 1'b0;
   endfunction

   // follow one received byte, leaving the results it causes in predicted;
   // returns whether the byte mattered (an idle non-header byte does not)
   function automatic bit absorb_byte(input logic [7:0] b);
      bit         taken;
      rx_result_t r;
      predicted.delete();
      taken = fr_open || (b == hdr_reg);
      if (fr_open) begin
         if (fr_pos == 0) begin
            fr_len = b;
            if (b >= MAX_LEN) begin
               predicted.push_back('{KIND_TOO_LONG, 3'd0, 6'd0, 8'd0, b, 1'b0});
               drop_frame();
            end else begin
               fr_pos = 1;
            end
         end else if (fr_pos == fr_len + 1) begin
            if (b == ~fr_len) begin
               len_ok = 1'b1;
               fr_pos++;
            end else begin
               predicted.push_back('{KIND_BAD_COMPL, 3'd0, 6'd0, 8'd0, fr_len, 1'b0});
               drop_frame();
            end
         end else if (fr_pos == fr_len + 2) begin
            if (b == tail_reg && len_ok) begin
               if (fr_len == 0) begin
                  predicted.push_back('{KIND_EMPTY, page_ctr, 6'd0, 8'd0, 8'd0, 1'b0});
               end else begin
                  for (int i = 0; i < fr_len; i++)
                     predicted.push_back('{KIND_PAYLOAD, page_ctr, 6'(i), frame_buf[i],
                                           fr_len, 1'b0});
               end
               page_ctr = (page_ctr == 3'(PAGE_COUNT - 1)) ? 3'd0 : page_ctr + 3'd1;
            end else begin
               predicted.push_back('{KIND_BAD_TAIL, 3'd0, 6'd0, 8'd0, fr_len, 1'b0});
            end
            drop_frame();
         end else begin
            frame_buf[fr_pos-1] = b;
            fr_pos++;
         end
      end
      // a frame-ending byte equal to the header opens the next frame
      if (!fr_open && b == hdr_reg) begin
         fr_open = 1'b1;
         fr_pos  = 0;
      end
      if (predicted.size() > 0) begin
         r = predicted.pop_back();
         r.last = 1'b1;
         predicted.push_back(r);
      end
      return taken;
   endfunction

   // one byte transfer with random idle cycles in front
   task automatic send_byte(input logic [7:0] b, input bit use_model);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.rx_byte <= b;
      do @(posedge clock); while (!req.ready);
      if (absorb_byte(b))
         bytes_taken++;
      if (use_model)
         while (predicted.size() > 0)
            awaited_results.push_back(predicted.pop_front());
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] v);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= v;
      if (idx == CSR_HEADER)
         hdr_reg = v;
      else if (idx == CSR_TAIL)
         tail_reg = v;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] hdr, input logic [7:0] tl);
      csr_put(CSR_HEADER, hdr);
      csr_put(CSR_TAIL, tl);
      csr_put(CSR_SPARE_A, 8'($urandom_range(255)));
      csr_put(CSR_SPARE_B, 8'($urandom_range(255)));
      csr_write_en <= 1'b0;
   endtask

   // wait for every expected result, then let a trailing byte finish
   task automatic settle();
      req.valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // header, length, payload, complement, tail; an oversize length ends the frame after
   // the length byte; complement and tail are sometimes spoiled
   task automatic send_frame(input int len);
      logic [7:0] lb;
      lb = len[7:0];
      send_byte(hdr_reg, 1'b1);
      send_byte(lb, 1'b1);
      if (len >= MAX_LEN)
         return;
      repeat (len) send_byte(8'($urandom_range(255)), 1'b1);
      if ($urandom_range(9) == 0)
         send_byte(~lb ^ 8'($urandom_range(255, 1)), 1'b1);
      else
         send_byte(~lb, 1'b1);
      if ($urandom_range(9) == 0)
         send_byte(tail_reg ^ 8'($urandom_range(255, 1)), 1'b1);
      else
         send_byte(tail_reg, 1'b1);
   endtask

   // mostly short well-formed frames, some noise, long and oversize lengths
   task automatic random_phase(input int target);
      int stop_at;
      int roll;
      stop_at = bytes_taken + target;
      while (bytes_taken < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 15)
            send_byte(8'($urandom_range(255)), 1'b1);
         else if (roll < 19)
            send_frame($urandom_range(255, MAX_LEN));
         else if (roll < 27)
            send_frame($urandom_range(MAX_LEN - 1, 8));
         else
            send_frame($urandom_range(7, 0));
      end
   endtask

   // receiver back-pressure
   always @(posedge clock)
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (awaited_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind %0d", rsp.kind));
         end else begin
            want_r = awaited_results.pop_front();
            if (rsp.kind !== want_r.kind)
               flag_mismatch($sformatf("kind %0h want %0h", rsp.kind, want_r.kind));
            if (rsp.page !== want_r.page)
               flag_mismatch($sformatf("page %0h want %0h", rsp.page, want_r.page));
            if (rsp.offset !== want_r.offset)
               flag_mismatch($sformatf("offset %0h want %0h", rsp.offset, want_r.offset));
            if (rsp.data_byte !== want_r.data_byte)
               flag_mismatch($sformatf("data_byte %0h want %0h", rsp.data_byte,
                                       want_r.data_byte));
            if (rsp.frame_length !== want_r.frame_length)
               flag_mismatch($sformatf("frame_length %0h want %0h", rsp.frame_length,
                                       want_r.frame_length));
            if (rsp.last !== want_r.last)
               flag_mismatch($sformatf("last %0h want %0h", rsp.last, want_r.last));
         end
      end
   end

   // main sequence
   initial begin
      mismatches     = 0;
      bytes_taken    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hdr_reg        = HEADER_RESET;
      tail_reg       = TAIL_RESET;
      page_ctr       = 3'd0;
      drop_frame();
      reset        <= 1'b1;
      req.valid    <= 1'b0;
      req.rx_byte  <= 8'd0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_HEADER;
      csr_wdata    <= 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset settings, no idling
      foreach (dir_table[n]) begin
         send_byte(dir_table[n].rx_byte, dir_table[n].how == BY_MODEL);
         if (dir_table[n].how == TYPED_ONE)
            awaited_results.push_back('{dir_table[n].kind, 3'd0, 6'd0, 8'd0,
                                        dir_table[n].frame_length, 1'b1});
      end
      settle();

      // lowest header, highest tail; sender mostly idle
      load_settings(8'h00, 8'hFF);
      send_idle_pct = 88;
      random_phase(15);
      settle();

      // highest header, lowest tail; receiver mostly stalled
      load_settings(8'hFF, 8'h00);
      send_idle_pct  = 0;
      recv_stall_pct = 88;
      random_phase(15);
      settle();

      // header equal to tail; both sides idle
      load_settings(8'h5A, 8'h5A);
      send_idle_pct  = 36;
      recv_stall_pct = 36;
      random_phase(15);
      settle();

      // random settings, full rate, one frame of the largest length
      load_settings(8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_frame(MAX_LEN - 1);
      random_phase(15);
      settle();

      repeat (TAIL_TICKS) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
design/lcfr_pkg.sv
design/lcfr_if.sv
design/lcfr_ctrl.sv
design/lcfr_dp.sv
design/length_checked_frame_receiver_top.sv
test/tb_top.sv
